// ===== src/upsps_pkg.sv =====
package upsps_pkg;

    // APB register map: register i at byte address 4*i
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_UPS_ENABLED      = 3'd0;
    localparam logic [IDX_W-1:0] REG_CRITICAL_SOC     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ALARM_SOC        = 3'd2;
    localparam logic [IDX_W-1:0] REG_START_CHARGE_SOC = 3'd3;
    localparam logic [IDX_W-1:0] REG_STOP_CHARGE_SOC  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ALARM_PERIOD_MS  = 3'd5;

    localparam logic        RST_UPS_ENABLED      = 1'b1;
    localparam logic [6:0]  RST_CRITICAL_SOC     = 7'd10;
    localparam logic [6:0]  RST_ALARM_SOC        = 7'd20;
    localparam logic [6:0]  RST_START_CHARGE_SOC = 7'd80;
    localparam logic [6:0]  RST_STOP_CHARGE_SOC  = 7'd100;
    localparam logic [17:0] RST_ALARM_PERIOD_MS  = 18'd180000;

    // Switch actions
    localparam logic [2:0] SW_CANCEL_INV_GRID_NOW  = 3'd0;
    localparam logic [2:0] SW_CANCEL_INV           = 3'd1;
    localparam logic [2:0] SW_CANCEL_INV_GRID_DLY  = 3'd2;
    localparam logic [2:0] SW_CANCEL_GRID          = 3'd3;
    localparam logic [2:0] SW_CANCEL_GRID_INV_DLY  = 3'd4;
    localparam logic [2:0] SW_CANCEL_GRID_GRID_NOW = 3'd5;

    // Charger and inverter commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Battery states
    localparam logic [2:0] BS_UNKNOWN        = 3'd0;
    localparam logic [2:0] BS_STANDBY        = 3'd1;
    localparam logic [2:0] BS_EMPTY          = 3'd2;
    localparam logic [2:0] BS_CHARGING       = 3'd3;
    localparam logic [2:0] BS_CHARGE_ERROR   = 3'd4;
    localparam logic [2:0] BS_DISCHARGING    = 3'd5;
    localparam logic [2:0] BS_DISCHARGE_CRIT = 3'd6;

    // Power states
    localparam logic [1:0] PS_NONE     = 2'd0;
    localparam logic [1:0] PS_GRID     = 2'd1;
    localparam logic [1:0] PS_INVERTER = 2'd2;

    typedef struct packed {
        logic              grid_voltage_ok;
        logic              switch_on_grid;
        logic              switch_on_inverter;
        logic              inverter_running;
        logic              inverter_healthy;
        logic              charger_running;
        logic              charger_preparing;
        logic              charger_drawing;
        logic              charger_healthy;
        logic              load_present;
        logic signed [7:0] battery_soc;
        logic [9:0]        elapsed_ms;
    } tick_t;

    typedef struct packed {
        logic [2:0] switch_action;
        logic [1:0] charger_command;
        logic [1:0] inverter_command;
        logic       beep;
        logic [2:0] batt_status;
        logic [1:0] power_state;
    } result_t;

    typedef struct packed {
        logic        ups_enabled;
        logic [6:0]  critical_soc;
        logic [6:0]  alarm_soc;
        logic [6:0]  start_charge_soc;
        logic [6:0]  stop_charge_soc;
        logic [17:0] alarm_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0] switch_action;
        logic [1:0] charger_command;
        logic [1:0] inverter_command;
        logic [2:0] batt_status;
        logic [1:0] power_state;
        logic       alarm_cond;
    } dec_t;

endpackage

// ===== src/upsps_if.sv =====
interface upsps_tick_if;
    logic                 valid;
    logic                 ready;
    upsps_pkg::tick_t     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface upsps_result_if;
    logic                 valid;
    logic                 ready;
    upsps_pkg::result_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/ups_power_path_supervisor.sv =====
// Channel   Direction  Payload                              Handshake
// tick      in         status flags, charge, elapsed ms     valid / ready
// result    out        switch, commands, beep, states       valid / ready
// apb       in/out     six configuration registers          psel / penable, pready high
//
// A tick is captured in an input register and decided from it combinationally,
// the result landing in an output register; one tick per cycle is sustained
// while the result is not stalled. A stalled result holds the output register
// while the input register still takes one more tick. Reset clears both valid
// flags and the alarm timer and loads the register defaults.
module ups_power_path_supervisor (
    input  logic                          clk,
    input  logic                          rst_n,
    upsps_tick_if.sink                    tick,
    upsps_result_if.source                result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [upsps_pkg::ADDR_W-1:0]  paddr,
    input  logic [upsps_pkg::DATA_W-1:0]  pwdata,
    output logic [upsps_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    upsps_pkg::cfg_t    cfg;
    upsps_pkg::dec_t    dec;
    upsps_pkg::tick_t   in_reg;
    upsps_pkg::result_t res_reg;
    upsps_pkg::result_t res_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               advance;
    logic               take_in;
    logic               beep;
    logic               alarm_active;

    upsps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    upsps_decide u_decide (
        .tick (in_reg),
        .cfg  (cfg),
        .dec  (dec)
    );

    upsps_alarm u_alarm (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cond       (dec.alarm_cond),
        .elapsed_ms (in_reg.elapsed_ms),
        .period_ms  (cfg.alarm_period_ms),
        .beep       (beep),
        .active     (alarm_active)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready = !in_valid_reg || advance;
    assign take_in    = tick.valid && tick.ready;

    assign result.valid   = out_valid_reg;
    assign result.payload = res_reg;

    always_comb
    begin
        res_next.switch_action    = dec.switch_action;
        res_next.charger_command  = dec.charger_command;
        res_next.inverter_command = dec.inverter_command;
        res_next.beep             = beep;
        res_next.batt_status      = dec.batt_status;
        res_next.power_state      = dec.power_state;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_reg <= tick.payload;
        if (advance)
            res_reg <= res_next;
    end

`ifndef ASSERT_OFF
    // A beep is only ever raised while discharging.
    a_beep_discharging: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.beep) |->
        ((res_reg.batt_status == upsps_pkg::BS_DISCHARGING) ||
         (res_reg.batt_status == upsps_pkg::BS_DISCHARGE_CRIT)))
        else $error("beep without discharge state");

    // An immediate grid selection never leaves the inverter as the source.
    a_grid_now_power: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg &&
         ((res_reg.switch_action == upsps_pkg::SW_CANCEL_INV_GRID_NOW) ||
          (res_reg.switch_action == upsps_pkg::SW_CANCEL_GRID_GRID_NOW))) |->
        (res_reg.power_state != upsps_pkg::PS_INVERTER))
        else $error("inverter power after immediate grid selection");

    // Starting the alarm timer always comes with a beep in the same transaction.
    a_alarm_start_beep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(alarm_active) |-> (out_valid_reg && res_reg.beep))
        else $error("alarm timer started without beep");
`endif

endmodule

// ===== src/upsps_cfg_regs.sv =====
module upsps_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [upsps_pkg::ADDR_W-1:0]  paddr,
    input  logic [upsps_pkg::DATA_W-1:0]  pwdata,
    output logic [upsps_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output upsps_pkg::cfg_t               cfg
);

    upsps_pkg::cfg_t                  cfg_reg;
    upsps_pkg::cfg_t                  cfg_next;
    logic [upsps_pkg::IDX_W-1:0]      idx;
    logic                             wr_en;

    assign idx    = paddr[upsps_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                upsps_pkg::REG_UPS_ENABLED:      cfg_next.ups_enabled      = pwdata[0];
                upsps_pkg::REG_CRITICAL_SOC:     cfg_next.critical_soc     = pwdata[6:0];
                upsps_pkg::REG_ALARM_SOC:        cfg_next.alarm_soc        = pwdata[6:0];
                upsps_pkg::REG_START_CHARGE_SOC: cfg_next.start_charge_soc = pwdata[6:0];
                upsps_pkg::REG_STOP_CHARGE_SOC:  cfg_next.stop_charge_soc  = pwdata[6:0];
                upsps_pkg::REG_ALARM_PERIOD_MS:  cfg_next.alarm_period_ms  = pwdata[17:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            upsps_pkg::REG_UPS_ENABLED:      prdata = {31'd0, cfg_reg.ups_enabled};
            upsps_pkg::REG_CRITICAL_SOC:     prdata = {25'd0, cfg_reg.critical_soc};
            upsps_pkg::REG_ALARM_SOC:        prdata = {25'd0, cfg_reg.alarm_soc};
            upsps_pkg::REG_START_CHARGE_SOC: prdata = {25'd0, cfg_reg.start_charge_soc};
            upsps_pkg::REG_STOP_CHARGE_SOC:  prdata = {25'd0, cfg_reg.stop_charge_soc};
            upsps_pkg::REG_ALARM_PERIOD_MS:  prdata = {14'd0, cfg_reg.alarm_period_ms};
            default:                         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ups_enabled      <= upsps_pkg::RST_UPS_ENABLED;
            cfg_reg.critical_soc     <= upsps_pkg::RST_CRITICAL_SOC;
            cfg_reg.alarm_soc        <= upsps_pkg::RST_ALARM_SOC;
            cfg_reg.start_charge_soc <= upsps_pkg::RST_START_CHARGE_SOC;
            cfg_reg.stop_charge_soc  <= upsps_pkg::RST_STOP_CHARGE_SOC;
            cfg_reg.alarm_period_ms  <= upsps_pkg::RST_ALARM_PERIOD_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== src/upsps_decide.sv =====
module upsps_decide (
    input  upsps_pkg::tick_t tick,
    input  upsps_pkg::cfg_t  cfg,
    output upsps_pkg::dec_t  dec
);

    logic       known;
    logic [6:0] soc_mag;
    logic       batt_ok;
    logic       low;
    logic       imm_grid;
    logic       grid_sel;
    logic       inv_sel;
    logic       chg_done;
    logic [2:0] sw;
    logic [1:0] chg_cmd;
    logic [1:0] inv_cmd;
    logic [2:0] batt_status;
    logic [1:0] pwr_state;
    logic       alarm_cond;

    // A negative charge is unknown; a known charge fits in seven bits.
    assign known   = ~tick.battery_soc[7];
    assign soc_mag = tick.battery_soc[6:0];
    assign batt_ok = known && (cfg.critical_soc < soc_mag);
    assign low     = !known || (soc_mag < cfg.alarm_soc);

    always_comb
    begin
        if (!batt_ok)
            sw = upsps_pkg::SW_CANCEL_INV_GRID_NOW;
        else if (tick.grid_voltage_ok)
            sw = tick.switch_on_grid ? upsps_pkg::SW_CANCEL_INV
                                     : upsps_pkg::SW_CANCEL_INV_GRID_DLY;
        else if (cfg.ups_enabled && tick.load_present)
            sw = tick.switch_on_inverter ? upsps_pkg::SW_CANCEL_GRID
                                         : upsps_pkg::SW_CANCEL_GRID_INV_DLY;
        else
            sw = tick.switch_on_inverter ? upsps_pkg::SW_CANCEL_GRID_GRID_NOW
                                         : upsps_pkg::SW_CANCEL_GRID;
    end

    // An immediate grid selection counts as done for the rest of the tick.
    assign imm_grid = (sw == upsps_pkg::SW_CANCEL_INV_GRID_NOW) ||
                      (sw == upsps_pkg::SW_CANCEL_GRID_GRID_NOW);
    assign grid_sel = tick.switch_on_grid || imm_grid;
    assign inv_sel  = tick.switch_on_inverter && !imm_grid;

    assign chg_done = (known && (cfg.stop_charge_soc <= soc_mag)) ||
                      (!tick.charger_preparing && !tick.charger_drawing);

    always_comb
    begin
        chg_cmd = upsps_pkg::CMD_NONE;
        if (tick.grid_voltage_ok && grid_sel)
        begin
            if (tick.charger_running)
            begin
                if (chg_done)
                    chg_cmd = upsps_pkg::CMD_STOP;
            end
            else if (known && (cfg.start_charge_soc >= soc_mag))
            begin
                chg_cmd = upsps_pkg::CMD_START;
            end
        end
        else if (tick.charger_running || tick.charger_preparing)
        begin
            chg_cmd = upsps_pkg::CMD_STOP;
        end
    end

    always_comb
    begin
        inv_cmd = upsps_pkg::CMD_NONE;
        if (inv_sel && cfg.ups_enabled && batt_ok && tick.load_present)
        begin
            if (!tick.inverter_running)
                inv_cmd = upsps_pkg::CMD_START;
        end
        else if (tick.inverter_running)
        begin
            inv_cmd = upsps_pkg::CMD_STOP;
        end
    end

    always_comb
    begin
        if (tick.inverter_healthy && inv_sel)
            batt_status = low ? upsps_pkg::BS_DISCHARGE_CRIT : upsps_pkg::BS_DISCHARGING;
        else if (tick.charger_running)
            batt_status = tick.charger_healthy ? upsps_pkg::BS_CHARGING
                                               : upsps_pkg::BS_CHARGE_ERROR;
        else if (!known)
            batt_status = upsps_pkg::BS_UNKNOWN;
        else if (cfg.critical_soc >= soc_mag)
            batt_status = upsps_pkg::BS_EMPTY;
        else
            batt_status = upsps_pkg::BS_STANDBY;
    end

    assign alarm_cond = batt_ok && low &&
                        ((batt_status == upsps_pkg::BS_DISCHARGING) ||
                         (batt_status == upsps_pkg::BS_DISCHARGE_CRIT));

    always_comb
    begin
        if (grid_sel)
            pwr_state = tick.grid_voltage_ok ? upsps_pkg::PS_GRID : upsps_pkg::PS_NONE;
        else
            pwr_state = tick.inverter_healthy ? upsps_pkg::PS_INVERTER
                                              : upsps_pkg::PS_NONE;
    end

    assign dec = {sw, chg_cmd, inv_cmd, batt_status, pwr_state, alarm_cond};

endmodule

// ===== src/upsps_alarm.sv =====
module upsps_alarm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        cond,
    input  logic [9:0]  elapsed_ms,
    input  logic [17:0] period_ms,
    output logic        beep,
    output logic        active
);

    logic        active_reg;
    logic        active_next;
    logic [17:0] elapsed_reg;
    logic [17:0] elapsed_next;
    logic [18:0] sum;
    logic [17:0] acc;
    logic        fire;

    // The timer advances before the decision and saturates at the period.
    assign sum  = {1'b0, elapsed_reg} + {9'd0, elapsed_ms};
    assign acc  = !active_reg ? elapsed_reg :
                  (sum > {1'b0, period_ms}) ? period_ms : sum[17:0];
    assign fire = acc >= period_ms;

    assign beep   = cond && (!active_reg || fire);
    assign active = active_reg;

    always_comb
    begin
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        if (advance)
        begin
            active_next  = cond;
            elapsed_next = (cond && active_reg && !fire) ? acc : 18'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            elapsed_reg <= 18'd0;
        end
        else
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule
